@@ rtl/core/ffca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int HEAP_GRANULES_DEF = 4096;
    localparam int FREE_SLOTS_DEF    = 64;
    localparam int OFFSET_GRANULE_LIMIT = 4096;
    localparam int GRANULE_W = 13;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_RANGE   = 3'd3,
        ST_BADSIZE = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HDR,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_HDRWR,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_WRITE,
        OP_REMOVE,
        OP_INSERT
    } cell_op_t;

    // one extent: start and length, both in granules
    typedef struct packed {
        logic [GRANULE_W-1:0] start;
        logic [GRANULE_W-1:0] length;
    } extent_t;

    // broadcast command from sequencer to every cell
    typedef struct packed {
        cell_op_t             op;
        logic [10:0]          pos;
        extent_t              data;
        logic [GRANULE_W-1:0] heap;
    } cell_ctrl_t;

endpackage

@@ rtl/core/ffca_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_cell
// One slot of the extent table; shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
module ffca_cell
    import ffca_pkg::*;
#(
    parameter int INDEX    = 0,
    parameter int INIT_LEN = OFFSET_GRANULE_LIMIT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  extent_t    left_in,
    input  extent_t    right_in,
    output extent_t    value
);

    extent_t val_reg, val_next;

    always_comb begin
        val_next = val_reg;
        unique case (ctrl.op)
            OP_INIT: begin
                val_next = '0;
                if (INDEX == 0) begin
                    val_next.length = ctrl.heap;
                end
            end
            OP_WRITE: begin
                if (ctrl.pos == 11'(INDEX)) begin
                    val_next = ctrl.data;
                end
            end
            OP_REMOVE: begin
                if (11'(INDEX) >= ctrl.pos) begin
                    val_next = right_in;
                end
            end
            OP_INSERT: begin
                if (11'(INDEX) == ctrl.pos) begin
                    val_next = ctrl.data;
                end else if (11'(INDEX) > ctrl.pos) begin
                    val_next = left_in;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= {GRANULE_W'(0),
                        (INDEX == 0) ? GRANULE_W'(INIT_LEN) : GRANULE_W'(0)};
        end else begin
            val_reg <= val_next;
        end
    end

    assign value = val_reg;

endmodule

@@ rtl/core/ffca_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_table
// Row of extent cells; slot zero sits at the head and the scan reads one slot.
// ----------------------------------------------------------------------------
module ffca_table
    import ffca_pkg::*;
#(
    parameter int FREE_SLOTS = FREE_SLOTS_DEF,
    parameter int INIT_LEN   = OFFSET_GRANULE_LIMIT,
    localparam int IW = $clog2(FREE_SLOTS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cell_ctrl_t    ctrl,
    input  logic [IW-1:0] rd_idx,
    output extent_t       rd_data
);

    extent_t cells [FREE_SLOTS];

    for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_cell
        extent_t l_in, r_in;
        if (i == 0) begin : g_l
            assign l_in = '0;
        end else begin : g_l
            assign l_in = cells[i-1];
        end
        if (i == FREE_SLOTS - 1) begin : g_r
            assign r_in = '0;
        end else begin : g_r
            assign r_in = cells[i+1];
        end
        ffca_cell #(.INDEX(i), .INIT_LEN(INIT_LEN)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .left_in  (l_in),
            .right_in (r_in),
            .value    (cells[i])
        );
    end

    always_ff @(posedge aclk) begin
        rd_data <= cells[rd_idx];
    end

endmodule

@@ rtl/core/first_fit_coalescing_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit heap allocator over an address-ordered extent table with merge.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                    Payload
// s_axis    in   s_tvalid/s_tready/s_tdata  command, request_bytes, offset
// m_axis    out  m_tvalid/m_tready/m_tdata  status, result_offset, granules
// cfg       in   cfg_we/cfg_wdata           heap_granules
//
// One transaction at a time; the first-fit scan reads one table slot per
// SCAN/DECIDE pass.
// Reset and each heap_granules write start a header-store clearing pass over
// min(HEAP_GRANULES, 4096) entries, during which s_tready stays low.
// A stalled m_tready holds the result and the next request.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator
    import ffca_pkg::*;
#(
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF,
    parameter int FREE_SLOTS    = FREE_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command, request_bytes[16:0], pointer_offset[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[2:0], result_offset[15:0], block_granules[12:0]
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata
);

    localparam int IW  = $clog2(FREE_SLOTS);
    localparam int CW  = $clog2(FREE_SLOTS + 1);
    localparam int LIM = (HEAP_GRANULES < OFFSET_GRANULE_LIMIT) ?
                         HEAP_GRANULES : OFFSET_GRANULE_LIMIT;
    localparam int HW  = $clog2(LIM);
    localparam int GW  = GRANULE_W;

    state_t state_reg, state_next;
    logic [GW-1:0] heap_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          cmd_reg;
    logic [GW-1:0] total_reg;
    logic [GW-1:0] g_reg;
    logic [GW-1:0] size_reg;
    logic          zero_reg;
    logic [HW-1:0] clr_reg;
    extent_t       prev_reg;
    logic          badptr_reg;
    status_t       st_reg;
    logic [15:0]   res_off_reg;
    logic [GW-1:0] res_gr_reg;
    logic          both_reg;
    cell_ctrl_t    shift_ctrl_reg, shift_ctrl_next;
    logic          hdr_we;
    logic [HW-1:0] hdr_addr;
    logic [GW-1:0] hdr_wd;
    logic [GW-1:0] hdr_rd;
    logic [GW-1:0] hdr_mem [LIM];
    cell_ctrl_t    ctrl;
    extent_t       rd;
    logic [GW-1:0] cfg_clamped;
    logic          scan_end;
    logic [GW:0]   g_end;
    logic [GW:0]   chk_end;
    logic [GW:0]   total_wide;
    logic          join_prev, join_next, p_nz;
    logic [GW:0]   prev_end;

    // -------- config clamp
    always_comb begin
        if (cfg_wdata < 13'd2) begin
            cfg_clamped = 13'd2;
        end else if ({1'b0, cfg_wdata} > 14'(LIM)) begin
            cfg_clamped = GW'(LIM);
        end else begin
            cfg_clamped = cfg_wdata;
        end
    end

    ffca_table #(.FREE_SLOTS(FREE_SLOTS), .INIT_LEN(LIM)) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .rd_idx  (idx_reg[IW-1:0]),
        .rd_data (rd)
    );

    // -------- header store
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_mem[hdr_addr] <= hdr_wd;
        end
        hdr_rd <= hdr_mem[hdr_addr];
    end

    assign scan_end   = (idx_reg >= count_reg);
    assign g_end      = {1'b0, g_reg} + {1'b0, size_reg};
    assign chk_end    = {1'b0, g_reg} + {1'b0, hdr_rd};
    assign total_wide = (GW+1)'(({1'b0, s_tdata[17:1]} + 18'd15) >> 4) + 14'd1;

    // -------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == HW'(LIM - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_tvalid) state_next = S_HDR;
            S_HDR:   state_next = S_CHECK;
            S_CHECK: begin
                if (cmd_reg == CMD_ALLOC) begin
                    state_next = zero_reg ? S_OUT : S_SCAN;
                end else begin
                    state_next = (badptr_reg || hdr_rd == '0 ||
                                  chk_end > {1'b0, heap_reg}) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN:   state_next = S_DECIDE;
            S_DECIDE: begin
                if (cmd_reg == CMD_ALLOC) begin
                    if (scan_end) state_next = S_OUT;
                    else if (rd.length >= total_reg) state_next = S_HDRWR;
                    else state_next = S_SCAN;
                end else begin
                    if (!scan_end && rd.start < g_reg) state_next = S_SCAN;
                    else state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (both_reg) state_next = S_SHIFT;
                else state_next = (st_reg == ST_OK) ? S_HDRWR : S_OUT;
            end
            S_HDRWR: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (cfg_we) begin
            state_next = S_CLEAR;
        end
    end

    // -------- outputs and datapath control
    always_comb begin
        ctrl      = '0;
        ctrl.op   = OP_NONE;
        ctrl.heap = cfg_clamped;
        hdr_we    = 1'b0;
        hdr_addr  = g_reg[HW-1:0];
        hdr_wd    = '0;
        unique case (state_reg)
            S_CLEAR: begin
                hdr_we   = 1'b1;
                hdr_addr = clr_reg;
            end
            S_HDRWR: begin
                hdr_we = 1'b1;
                hdr_wd = (cmd_reg == CMD_ALLOC) ? total_reg : '0;
            end
            S_DECIDE: begin
                ctrl.pos = 11'(idx_reg);
                if (cmd_reg == CMD_ALLOC && !scan_end && rd.length >= total_reg) begin
                    if (rd.length != total_reg) begin
                        ctrl.op          = OP_WRITE;
                        ctrl.data.start  = rd.start + total_reg;
                        ctrl.data.length = rd.length - total_reg;
                    end else begin
                        ctrl.op = OP_REMOVE;
                    end
                end
            end
            S_SHIFT: begin
                // merge into slot idx-1 or idx, insert at idx, or remove idx on the second pass
                ctrl = shift_ctrl_reg;
            end
            default: begin
            end
        endcase
        if (cfg_we) begin
            ctrl.op   = OP_INIT;
            ctrl.heap = cfg_clamped;
            hdr_we    = 1'b0;
        end
    end

    // -------- free merge decision, registered in DECIDE
    assign p_nz      = (idx_reg != '0);
    assign prev_end  = {1'b0, prev_reg.start} + {1'b0, prev_reg.length};
    assign join_next = !scan_end && (g_end == {1'b0, rd.start});
    assign join_prev = p_nz && (prev_end == {1'b0, g_reg});

    always_comb begin
        shift_ctrl_next = shift_ctrl_reg;
        if (state_reg == S_DECIDE && cmd_reg == CMD_FREE &&
            (scan_end || rd.start >= g_reg)) begin
            shift_ctrl_next      = '0;
            shift_ctrl_next.heap = heap_reg;
            priority if (join_prev && join_next) begin
                // second pass removes slot idx after widening idx-1
                shift_ctrl_next.op          = OP_WRITE;
                shift_ctrl_next.pos         = 11'(idx_reg - 1'b1);
                shift_ctrl_next.data.start  = prev_reg.start;
                shift_ctrl_next.data.length = prev_reg.length + size_reg + rd.length;
            end else if (join_prev) begin
                shift_ctrl_next.op          = OP_WRITE;
                shift_ctrl_next.pos         = 11'(idx_reg - 1'b1);
                shift_ctrl_next.data.start  = prev_reg.start;
                shift_ctrl_next.data.length = prev_reg.length + size_reg;
            end else if (join_next) begin
                shift_ctrl_next.op          = OP_WRITE;
                shift_ctrl_next.pos         = 11'(idx_reg);
                shift_ctrl_next.data.start  = g_reg;
                shift_ctrl_next.data.length = rd.length + size_reg;
            end else if (count_reg >= CW'(FREE_SLOTS)) begin
                shift_ctrl_next.op = OP_NONE;
            end else begin
                shift_ctrl_next.op          = OP_INSERT;
                shift_ctrl_next.pos         = 11'(idx_reg);
                shift_ctrl_next.data.start  = g_reg;
                shift_ctrl_next.data.length = size_reg;
            end
        end else if (state_reg == S_SHIFT && both_reg) begin
            shift_ctrl_next.op  = OP_REMOVE;
            shift_ctrl_next.pos = 11'(idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_ctrl_reg <= '0;
        end else begin
            shift_ctrl_reg <= shift_ctrl_next;
        end
    end

    // -------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            heap_reg  <= GW'(LIM);
            count_reg <= CW'(1);
            clr_reg   <= '0;
            idx_reg   <= '0;
            both_reg  <= 1'b0;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                heap_reg  <= cfg_clamped;
                count_reg <= CW'(1);
                clr_reg   <= '0;
            end else begin
                if (state_reg == S_CLEAR) begin
                    clr_reg <= clr_reg + 1'b1;
                end
                unique case (state_reg)
                    S_IDLE: begin
                        if (s_tvalid) begin
                            cmd_reg    <= s_tdata[0];
                            zero_reg   <= (s_tdata[17:1] == '0);
                            total_reg  <= total_wide[GW] ? '1 : total_wide[GW-1:0];
                            g_reg      <= GW'(s_tdata[33:22]) - 1'b1;
                            badptr_reg <= (s_tdata[33:18] < 16'd16) ||
                                          (s_tdata[21:18] != 4'd0) ||
                                          ({1'b0, s_tdata[33:22]} > heap_reg);
                            idx_reg    <= '0;
                            prev_reg   <= '0;
                            both_reg   <= 1'b0;
                            st_reg     <= ST_OK;
                            res_off_reg <= '0;
                            res_gr_reg  <= '0;
                        end
                    end
                    S_CHECK: begin
                        size_reg <= hdr_rd;
                        if (cmd_reg == CMD_ALLOC) begin
                            if (zero_reg) st_reg <= ST_ZERO;
                        end else if (badptr_reg) begin
                            st_reg <= ST_RANGE;
                        end else if (hdr_rd == '0 || chk_end > {1'b0, heap_reg}) begin
                            st_reg <= ST_BADSIZE;
                        end
                    end
                    S_DECIDE: begin
                        if (cmd_reg == CMD_ALLOC) begin
                            if (scan_end) begin
                                st_reg <= ST_OOM;
                            end else if (rd.length >= total_reg) begin
                                g_reg       <= rd.start;
                                res_off_reg <= {rd.start[11:0] + 12'd1, 4'd0};
                                res_gr_reg  <= total_reg;
                                if (rd.length == total_reg) count_reg <= count_reg - 1'b1;
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end else if (!scan_end && rd.start < g_reg) begin
                            prev_reg <= rd;
                            idx_reg  <= idx_reg + 1'b1;
                        end else begin
                            both_reg <= join_prev && join_next;
                            if (join_prev && join_next) begin
                                count_reg <= count_reg - 1'b1;
                            end else if (!join_prev && !join_next) begin
                                if (count_reg >= CW'(FREE_SLOTS)) st_reg <= ST_FULL;
                                else count_reg <= count_reg + 1'b1;
                            end
                            res_gr_reg <= size_reg;
                        end
                    end
                    S_SHIFT: begin
                        if (both_reg) begin
                            both_reg <= 1'b0;
                        end
                        if (st_reg != ST_OK) res_gr_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !cfg_we;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {res_gr_reg, res_off_reg, st_reg};

endmodule

@@ rtl/core/ffca_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks on the allocator's result channel and request handshake.
// ----------------------------------------------------------------------------
module ffca_checker
    import ffca_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[31:3] == '0)
        else $error("failed transaction carries data");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd5)
        else $error("bad status");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while result pending");

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/tb_first_fit_coalescing_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_coalescing_allocator
// Self-checking bench for the first-fit coalescing heap allocator. It sends
// allocate and free requests on the input stream and checks every result
// against an extent-table model kept in the bench. The run covers several
// heap sizes, the extremes among them, directed corner requests, a table-full
// fragmentation sequence, random traffic, random gaps and stalls on both
// sides, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_first_fit_coalescing_allocator;
    import ffca_pkg::*;

    localparam int SLOTS  = FREE_SLOTS_DEF;
    localparam int HEAP_N = HEAP_GRANULES_DEF;

    typedef struct {
        status_t     st;
        logic [15:0] off;
        logic [12:0] gran;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // command, request_bytes[16:0], pointer_offset[15:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // status[2:0], result_offset[15:0], block_granules[12:0]
    logic        cfg_we;
    logic [12:0] cfg_wdata;

    int ext_start [SLOTS];
    int ext_len   [SLOTS];
    int ext_cnt;
    int hdr_size  [HEAP_N];
    int heap_g;

    logic [39:0]   request_q[$];
    alloc_result_t result_q[$];
    logic [15:0]   live_ptrs[$];

    int  snd_idle;
    int  rcv_stall;
    int  hold_cycles;
    bit  s_taken;
    int  fail_cnt;
    int  n_checked;
    int  status_seen[6];
    int  heaps_used;

    first_fit_coalescing_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb_first_fit_coalescing_allocator: FAIL");
        $finish;
    end

    function automatic logic [39:0] pack_req(logic cmd, logic [16:0] bytes, logic [15:0] ptr);
        return {6'd0, ptr, bytes, cmd};
    endfunction

    task automatic heap_reinit(input logic [12:0] value);
        int v;
        v = int'(value);
        if (v < 2) v = 2;
        if (v > HEAP_N) v = HEAP_N;
        if (v > OFFSET_GRANULE_LIMIT) v = OFFSET_GRANULE_LIMIT;
        heap_g = v;
        for (int i = 0; i < SLOTS; i++) begin
            ext_start[i] = 0;
            ext_len[i] = 0;
        end
        for (int i = 0; i < HEAP_N; i++) hdr_size[i] = 0;
        ext_len[0] = heap_g;
        ext_cnt = 1;
    endtask

    task automatic drop_extent(input int p);
        for (int i = p; i + 1 < ext_cnt; i++) begin
            ext_start[i] = ext_start[i+1];
            ext_len[i] = ext_len[i+1];
        end
        ext_cnt--;
        ext_start[ext_cnt] = 0;
        ext_len[ext_cnt] = 0;
    endtask

    task automatic serve_request(input logic [39:0] req, output alloc_result_t res);
        int bytes, ptr, total, g, size, p;
        bit jp, jn, done;
        res.st = ST_OK;
        res.off = '0;
        res.gran = '0;
        bytes = int'(req[17:1]);
        ptr = int'(req[33:18]);
        if (req[0] == CMD_ALLOC) begin
            if (bytes == 0) begin
                res.st = ST_ZERO;
                return;
            end
            total = (bytes + 15) / 16 + 1;
            done = 0;
            for (int i = 0; i < ext_cnt && !done; i++) begin
                if (ext_len[i] >= total) begin
                    g = ext_start[i];
                    if (ext_len[i] - total >= 1) begin
                        ext_start[i] = g + total;
                        ext_len[i] -= total;
                    end else begin
                        drop_extent(i);
                    end
                    if (g < HEAP_N) hdr_size[g] = total;
                    res.off = 16'((g + 1) * 16);
                    res.gran = 13'(total);
                    done = 1;
                end
            end
            if (!done) res.st = ST_OOM;
            return;
        end
        if (ptr < 16 || ptr % 16 != 0) begin
            res.st = ST_RANGE;
            return;
        end
        g = ptr / 16 - 1;
        if (g >= heap_g || g >= HEAP_N) begin
            res.st = ST_RANGE;
            return;
        end
        size = hdr_size[g];
        if (size < 1 || g + size > heap_g) begin
            res.st = ST_BADSIZE;
            return;
        end
        p = 0;
        while (p < ext_cnt && ext_start[p] < g) p++;
        jn = (p < ext_cnt) && (g + size == ext_start[p]);
        jp = (p > 0) && (ext_start[p-1] + ext_len[p-1] == g);
        if (jp && jn) begin
            ext_len[p-1] += size + ext_len[p];
            drop_extent(p);
        end else if (jp) begin
            ext_len[p-1] += size;
        end else if (jn) begin
            ext_start[p] = g;
            ext_len[p] += size;
        end else begin
            if (ext_cnt >= SLOTS) begin
                res.st = ST_FULL;
                return;
            end
            for (int i = ext_cnt; i > p; i--) begin
                ext_start[i] = ext_start[i-1];
                ext_len[i] = ext_len[i-1];
            end
            ext_start[p] = g;
            ext_len[p] = size;
            ext_cnt++;
        end
        hdr_size[g] = 0;
        res.gran = 13'(size);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (request_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                s_tdata <= request_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    // monitor
    always @(posedge aclk) begin
        alloc_result_t exp_r;
        alloc_result_t got;
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            serve_request(s_tdata, exp_r);
            result_q.push_back(exp_r);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.st = status_t'(m_tdata[2:0]);
            got.off = m_tdata[18:3];
            got.gran = m_tdata[31:19];
            if (result_q.size() == 0) begin
                $display("%0t: unexpected transaction, actual st=%0d off=%h gran=%0d",
                         $time, got.st, got.off, got.gran);
                fail_cnt++;
            end else begin
                exp_r = result_q.pop_front();
                n_checked++;
                if (exp_r.st != got.st || exp_r.off != got.off || exp_r.gran != got.gran) begin
                    $display("%0t: mismatch expected st=%0d off=%h gran=%0d, actual st=%0d off=%h gran=%0d",
                             $time, exp_r.st, exp_r.off, exp_r.gran, got.st, got.off, got.gran);
                    fail_cnt++;
                end
                if (got.st <= ST_FULL) status_seen[got.st]++;
                if (got.st == ST_OK && got.off != 0) live_ptrs.push_back(got.off);
            end
        end
    end

    task automatic drain();
        while (request_q.size() > 0 || s_tvalid || result_q.size() > 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic set_heap(input logic [12:0] value);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        heap_reinit(value);
        live_ptrs.delete();
        heaps_used++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_batch(input int n);
        int r, k;
        logic [16:0] bytes;
        logic [15:0] ptr;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 55 || live_ptrs.size() == 0) begin
                k = $urandom_range(99);
                if (k < 80) bytes = 17'($urandom_range(96, 1));
                else if (k < 95) bytes = 17'($urandom_range(2000, 1));
                else if (k < 99) bytes = 17'($urandom_range(65536, 0));
                else bytes = '0;
                request_q.push_back(pack_req(CMD_ALLOC, bytes, 16'($urandom)));
            end else if (r < 94) begin
                k = $urandom_range(live_ptrs.size() - 1);
                ptr = live_ptrs[k];
                if ($urandom_range(9) != 0) live_ptrs.delete(k);
                request_q.push_back(pack_req(CMD_FREE, 17'($urandom), ptr));
            end else if (r < 97) begin
                request_q.push_back(pack_req(CMD_FREE, 17'($urandom), 16'($urandom)));
            end else begin
                ptr = 16'(live_ptrs[$urandom_range(live_ptrs.size() - 1)] + 16);
                request_q.push_back(pack_req(CMD_FREE, 17'($urandom), ptr));
            end
        end
        drain();
    endtask

    task automatic run_phase(input logic [12:0] heap, input int idle, input int stall, input int n);
        set_heap(heap);
        snd_idle = idle;
        rcv_stall = stall;
        for (int b = 0; b < n; b += 15) random_batch(15);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        snd_idle = 0;
        rcv_stall = 0;
        hold_cycles = 0;
        s_taken = 0;
        fail_cnt = 0;
        n_checked = 0;
        heaps_used = 1;
        heap_reinit(13'd4096);
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // corner requests on the reset heap
        request_q.push_back(pack_req(CMD_ALLOC, 17'd0, 16'd0));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd1, 16'hFFFF));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd16, 16'd0));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd17, 16'd0));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd65536, 16'd0));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd65535, 16'd0));
        request_q.push_back(pack_req(CMD_FREE, 17'h1FFFF, 16'd0));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'd8));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'd48));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'd16));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'd16));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'hFFF0));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd65504, 16'd0));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd1, 16'd0));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'd64));
        request_q.push_back(pack_req(CMD_FREE, 17'd0, 16'd32));
        request_q.push_back(pack_req(CMD_ALLOC, 17'd100, 16'd0));
        drain();

        // fragment the heap until the extent table is full
        set_heap(13'd4096);
        for (int i = 0; i < 140; i++) request_q.push_back(pack_req(CMD_ALLOC, 17'd16, 16'd0));
        drain();
        for (int i = 0; i < live_ptrs.size(); i += 2)
            request_q.push_back(pack_req(CMD_FREE, 17'd0, live_ptrs[i]));
        drain();

        run_phase(13'd0, 0, 0, 150);
        run_phase(13'd1, 57, 0, 60);
        run_phase(13'd8191, 0, 57, 150);
        run_phase(13'd64, 24, 24, 150);
        run_phase(13'd300, 0, 0, 150);

        // long output hold-off while requests keep coming
        snd_idle = 0;
        rcv_stall = 0;
        @(negedge aclk);
        hold_cycles = 600;
        random_batch(30);

        run_phase(13'd2000, 57, 57, 120);
        run_phase(13'd4096, 24, 24, 150);

        drain();
        $display("Checked %0d results over %0d heap settings: ok %0d, zero %0d, oom %0d",
                 n_checked, heaps_used, status_seen[ST_OK], status_seen[ST_ZERO],
                 status_seen[ST_OOM]);
        $display("  range %0d, bad size %0d, table full %0d",
                 status_seen[ST_RANGE], status_seen[ST_BADSIZE], status_seen[ST_FULL]);
        if (fail_cnt == 0) begin
            $display("tb_first_fit_coalescing_allocator: PASS");
        end else begin
            $display("tb_first_fit_coalescing_allocator: FAIL");
        end
        $finish;
    end

endmodule
